// File: rtl/cdsu_pkg.sv
// ----------------------------------------------------------------------------
// cdsu_pkg
// shared constants, codes and types of the character display span updater
// ----------------------------------------------------------------------------
package cdsu_pkg;

  // default geometry
  localparam int MAX_COLS_DEF = 20;
  localparam int MAX_ROWS_DEF = 4;

  // fixed field widths
  localparam int CHAR_W     = 8;
  localparam int CMD_W      = 2;
  localparam int KIND_W     = 2;
  localparam int DCOL_W     = 6;
  localparam int DSUM_W     = DCOL_W + 1;
  localparam int COL_IN_W   = 8;
  localparam int ROW_IN_W   = 8;
  localparam int COLS_REG_W = 5;
  localparam int ROWS_REG_W = 3;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int FROW_W     = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POS   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;

  localparam logic [COLS_REG_W-1:0] COLS_RESET = 5'd20;
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h00;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_CLR,
    SEQ_POS,
    SEQ_RD,
    SEQ_EMIT
  } seq_state_t;

  // flush request handed from the front end to the sequencer
  typedef struct packed {
    logic              start;
    logic              in_range;
    logic [FROW_W-1:0] row;
  } flush_req_t;

endpackage

// File: rtl/cdsu_if.sv
// ----------------------------------------------------------------------------
// cdsu_req_if / cdsu_rsp_if
// command and result channels, valid/ready with payload
// ----------------------------------------------------------------------------
interface cdsu_req_if import cdsu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [COL_IN_W-1:0] column;
  logic [ROW_IN_W-1:0] row;
  logic [CHAR_W-1:0]   char_code;

  modport source (output valid, cmd, column, row, char_code, input ready);
  modport sink   (input valid, cmd, column, row, char_code, output ready);
endinterface

interface cdsu_rsp_if import cdsu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [DCOL_W-1:0] device_column;
  logic              device_row;
  logic [CHAR_W-1:0] out_char;
  logic              last;

  modport source (output valid, kind, device_column, device_row, out_char, last,
                  input ready);
  modport sink   (input valid, kind, device_column, device_row, out_char, last,
                  output ready);
endinterface

// File: rtl/cdsu_store.sv
// ----------------------------------------------------------------------------
// cdsu_store
// character memory, one write and one registered read port, per-entry valid
// bits so an unwritten or cleared entry reads as the reset character
// ----------------------------------------------------------------------------
module cdsu_store import cdsu_pkg::*; #(
  parameter int                DEPTH     = MAX_COLS_DEF * MAX_ROWS_DEF,
  parameter int                AW        = 7,
  parameter int                CW        = 7,
  parameter logic [CHAR_W-1:0] RESET_VAL = CHAR_SPACE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [CHAR_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [CHAR_W-1:0] rd_data,
  input  logic              clr_en,
  input  logic [CW-1:0]     clr_limit
);

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : RESET_VAL;
    end
  end

  // clear drops the valid bit of every entry below the limit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (clr_en && (CW'(i) < clr_limit)) begin
          vld[i] <= 1'b0;
        end else if (wr_en && (wr_addr == AW'(i))) begin
          vld[i] <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/cdsu_seq.sv
// ----------------------------------------------------------------------------
// cdsu_seq
// flush sequencer: scans one row against the shadow copy, then sends the
// clear-display, set-position and character beats through an output register
// ----------------------------------------------------------------------------
module cdsu_seq import cdsu_pkg::*; #(
  parameter int AW = 7,
  parameter int XW = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  flush_req_t        freq,
  input  logic [AW-1:0]     base_in,
  input  logic [XW-1:0]     width,
  output logic              idle,
  output logic              frame_rd_en,
  output logic [AW-1:0]     frame_rd_addr,
  input  logic [CHAR_W-1:0] frame_rd_data,
  output logic              shown_rd_en,
  output logic [AW-1:0]     shown_rd_addr,
  input  logic [CHAR_W-1:0] shown_rd_data,
  output logic              shown_wr_en,
  output logic [AW-1:0]     shown_wr_addr,
  output logic [CHAR_W-1:0] shown_wr_data,
  cdsu_rsp_if.source        rsp
);

  localparam int SW = AW + 1;

  seq_state_t        state, state_next;
  logic              first_pending;
  logic [AW-1:0]     base;
  logic [FROW_W-1:0] frow;
  logic [XW-1:0]     x;
  logic [XW-1:0]     first_x;
  logic [XW-1:0]     last_x;
  logic              any;
  logic              s_valid;
  logic [XW-1:0]     s_x;
  logic [AW-1:0]     s_addr;

  logic              out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [DCOL_W-1:0] out_col;
  logic              out_row;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;

  logic              out_free;
  logic              differ;
  logic [SW-1:0]     addr_sum;
  logic [DSUM_W-1:0] dcol_sum;
  logic              scan_rd;

  logic              ld;
  logic [KIND_W-1:0] ld_kind;
  logic [DCOL_W-1:0] ld_col;
  logic              ld_row;
  logic [CHAR_W-1:0] ld_char;
  logic              ld_last;

  assign out_free = !out_valid || rsp.ready;
  assign differ   = s_valid && (frame_rd_data != shown_rd_data);
  assign addr_sum = {1'b0, base} + SW'(x);
  assign scan_rd  = (state == SEQ_SCAN) && (x < width);
  // rows 2 and 3 sit to the right of rows 0 and 1 on the device
  assign dcol_sum = {{(DSUM_W-XW){1'b0}}, first_x}
                  + (frow[1] ? {{(DSUM_W-XW){1'b0}}, width} : DSUM_W'(0));

  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: begin
        if (freq.start) begin
          if (freq.in_range) begin
            state_next = SEQ_SCAN;
          end else if (first_pending) begin
            state_next = SEQ_CLR;
          end
        end
      end
      SEQ_SCAN: begin
        if (!scan_rd && !s_valid) begin
          if (first_pending) begin
            state_next = SEQ_CLR;
          end else if (any) begin
            state_next = SEQ_POS;
          end else begin
            state_next = SEQ_IDLE;
          end
        end
      end
      SEQ_CLR: begin
        if (out_free) begin
          state_next = any ? SEQ_POS : SEQ_IDLE;
        end
      end
      SEQ_POS: begin
        if (out_free) begin
          state_next = SEQ_RD;
        end
      end
      SEQ_RD: begin
        state_next = SEQ_EMIT;
      end
      SEQ_EMIT: begin
        if (out_free) begin
          state_next = (x == last_x) ? SEQ_IDLE : SEQ_RD;
        end
      end
      default: begin
        state_next = SEQ_IDLE;
      end
    endcase
  end

  always_comb begin
    idle          = (state == SEQ_IDLE);
    frame_rd_en   = scan_rd || (state == SEQ_RD);
    frame_rd_addr = addr_sum[AW-1:0];
    shown_rd_en   = scan_rd;
    shown_rd_addr = addr_sum[AW-1:0];
    shown_wr_en   = differ;
    shown_wr_addr = s_addr;
    shown_wr_data = frame_rd_data;
    ld            = 1'b0;
    ld_kind       = KIND_CLEAR;
    ld_col        = '0;
    ld_row        = 1'b0;
    ld_char       = CHAR_ZERO;
    ld_last       = 1'b0;
    unique case (state)
      SEQ_CLR: begin
        ld      = out_free;
        ld_last = !any;
      end
      SEQ_POS: begin
        ld      = out_free;
        ld_kind = KIND_POS;
        ld_col  = dcol_sum[DCOL_W-1:0];
        ld_row  = frow[0];
      end
      SEQ_EMIT: begin
        ld      = out_free;
        ld_kind = KIND_CHAR;
        ld_char = frame_rd_data;
        ld_last = (x == last_x);
      end
      SEQ_IDLE, SEQ_SCAN, SEQ_RD: begin
        ld = 1'b0;
      end
      default: begin
        ld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= SEQ_IDLE;
      first_pending <= 1'b1;
      any           <= 1'b0;
      s_valid       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state   <= state_next;
      s_valid <= scan_rd;
      if (state == SEQ_IDLE && freq.start) begin
        any <= 1'b0;
      end else if (differ) begin
        any <= 1'b1;
      end
      if (state == SEQ_CLR && out_free) begin
        first_pending <= 1'b0;
      end
      if (ld) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s_x    <= x;
    s_addr <= addr_sum[AW-1:0];
    if (state == SEQ_IDLE && freq.start) begin
      base <= base_in;
      frow <= freq.row;
      x    <= '0;
    end else if (scan_rd) begin
      x <= x + XW'(1);
    end else if (state == SEQ_POS && out_free) begin
      x <= first_x;
    end else if (state == SEQ_EMIT && out_free && (x != last_x)) begin
      x <= x + XW'(1);
    end
    if (differ) begin
      if (!any) begin
        first_x <= s_x;
      end
      last_x <= s_x;
    end
    if (ld) begin
      out_kind <= ld_kind;
      out_col  <= ld_col;
      out_row  <= ld_row;
      out_char <= ld_char;
      out_last <= ld_last;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.kind          = out_kind;
  assign rsp.device_column = out_col;
  assign rsp.device_row    = out_row;
  assign rsp.out_char      = out_char;
  assign rsp.last          = out_last;

  // pending bit drops only together with a clear-display beat
  a_pending_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(first_pending) |-> (out_valid && out_kind == KIND_CLEAR))
    else $error("pending clear dropped without a clear-display beat");

  // character cursor stays inside the changed span
  a_emit_span: assert property (@(posedge clk) disable iff (rst)
    (state == SEQ_EMIT || state == SEQ_RD) |-> (x >= first_x && x <= last_x))
    else $error("character cursor outside the changed span");

  // position and character beats only after a change was found
  a_any_before_pos: assert property (@(posedge clk) disable iff (rst)
    (state == SEQ_POS || state == SEQ_EMIT) |-> any)
    else $error("position or character beat without a changed cell");

  // clear-display beat only once after reset
  a_clr_pending: assert property (@(posedge clk) disable iff (rst)
    (state == SEQ_CLR) |-> first_pending)
    else $error("second clear-display beat");

endmodule

// File: rtl/char_display_dirty_span_update.sv
// ----------------------------------------------------------------------------
// char_display_dirty_span_update
// character frame store with a shadow copy of the display, row flushes send
// only the span of changed cells
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  req      in   cmd, column, row, char_code
//  rsp      out  kind, device_column, device_row, out_char, last
//  cfg_*    in   cfg_index, cfg_data (write enable, no handshake)
//
//  write and clear commands are taken back to back while no flush is in progress
//  a flush scans the row at one cell a cycle, then sends its beats, with a
//  frame store read before each character beat
//  rst is synchronous; the stores need no clearing pass, valid bits do it
//  a stalled rsp holds the sequencer; the output register lets the next
//  command in while the final beat of a flush waits
// ----------------------------------------------------------------------------
module char_display_dirty_span_update import cdsu_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cdsu_req_if.sink              req,
  cdsu_rsp_if.source            rsp
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int XW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);

  // configuration registers
  logic [COLS_REG_W-1:0] cols_reg;
  logic [ROWS_REG_W-1:0] rows_reg;

  // effective geometry
  logic [XW-1:0] w_eff;
  logic [RW-1:0] h_eff;

  logic                acc;
  logic                seq_idle;
  logic [ROW_IN_W-1:0] row_m1;
  logic [COL_IN_W-1:0] col_m1;
  logic [FROW_W-1:0]   row_sel;
  logic [CW-1:0]       base;
  logic [CW-1:0]       wr_sum;
  logic                col_ok;
  logic                row_ok;
  logic                frame_wr;
  logic                frame_clr;
  logic [CW-1:0]       clr_limit;
  flush_req_t          freq;

  logic              frame_rd_en;
  logic [AW-1:0]     frame_rd_addr;
  logic [CHAR_W-1:0] frame_rd_data;
  logic              shown_rd_en;
  logic [AW-1:0]     shown_rd_addr;
  logic [CHAR_W-1:0] shown_rd_data;
  logic              shown_wr_en;
  logic [AW-1:0]     shown_wr_addr;
  logic [CHAR_W-1:0] shown_wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_reg <= COLS_RESET;
      rows_reg <= ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLUMNS: cols_reg <= cfg_data[COLS_REG_W-1:0];
        CFG_ROWS:    rows_reg <= cfg_data[ROWS_REG_W-1:0];
        default:     cols_reg <= cols_reg;
      endcase
    end
  end

  // clamp the registers to the storage geometry
  always_comb begin
    if (cols_reg == '0) begin
      w_eff = XW'(1);
    end else if (int'(cols_reg) > MAX_COLS) begin
      w_eff = XW'(MAX_COLS);
    end else begin
      w_eff = XW'(cols_reg);
    end
    if (rows_reg == '0) begin
      h_eff = RW'(1);
    end else if (int'(rows_reg) > MAX_ROWS) begin
      h_eff = RW'(MAX_ROWS);
    end else begin
      h_eff = RW'(rows_reg);
    end
  end

  // commands are taken whenever no flush is in progress
  assign req.ready = seq_idle;
  assign acc       = req.valid && req.ready;

  // writes use 1-based positions, flushes a 0-based row
  assign row_m1  = req.row - ROW_IN_W'(1);
  assign col_m1  = req.column - COL_IN_W'(1);
  assign row_sel = (req.cmd == CMD_WRITE) ? row_m1[FROW_W-1:0] : req.row[FROW_W-1:0];
  assign base    = CW'(row_sel) * CW'(w_eff);
  assign wr_sum  = base + CW'(col_m1[XW-1:0]);

  assign col_ok = (req.column != '0)
               && (req.column <= {{(COL_IN_W-XW){1'b0}}, w_eff});
  assign row_ok = (req.row != '0)
               && (req.row <= {{(ROW_IN_W-RW){1'b0}}, h_eff});

  assign frame_wr  = acc && (req.cmd == CMD_WRITE) && col_ok && row_ok;
  assign frame_clr = acc && (req.cmd == CMD_CLEAR);
  // a clear only touches the cells in use
  assign clr_limit = CW'(w_eff) * CW'(h_eff);

  assign freq.start    = acc && (req.cmd == CMD_FLUSH);
  assign freq.in_range = (req.row < {{(ROW_IN_W-RW){1'b0}}, h_eff});
  assign freq.row      = req.row[FROW_W-1:0];

  // frame store, resets to spaces
  cdsu_store #(
    .DEPTH     (DEPTH),
    .AW        (AW),
    .CW        (CW),
    .RESET_VAL (CHAR_SPACE)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (frame_wr),
    .wr_addr   (wr_sum[AW-1:0]),
    .wr_data   (req.char_code),
    .rd_en     (frame_rd_en),
    .rd_addr   (frame_rd_addr),
    .rd_data   (frame_rd_data),
    .clr_en    (frame_clr),
    .clr_limit (clr_limit)
  );

  // shadow of what the display shows, resets to zero, never cleared
  cdsu_store #(
    .DEPTH     (DEPTH),
    .AW        (AW),
    .CW        (CW),
    .RESET_VAL (CHAR_ZERO)
  ) u_shown (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (shown_wr_en),
    .wr_addr   (shown_wr_addr),
    .wr_data   (shown_wr_data),
    .rd_en     (shown_rd_en),
    .rd_addr   (shown_rd_addr),
    .rd_data   (shown_rd_data),
    .clr_en    (1'b0),
    .clr_limit (CW'(0))
  );

  cdsu_seq #(
    .AW (AW),
    .XW (XW)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .freq          (freq),
    .base_in       (base[AW-1:0]),
    .width         (w_eff),
    .idle          (seq_idle),
    .frame_rd_en   (frame_rd_en),
    .frame_rd_addr (frame_rd_addr),
    .frame_rd_data (frame_rd_data),
    .shown_rd_en   (shown_rd_en),
    .shown_rd_addr (shown_rd_addr),
    .shown_rd_data (shown_rd_data),
    .shown_wr_en   (shown_wr_en),
    .shown_wr_addr (shown_wr_addr),
    .shown_wr_data (shown_wr_data),
    .rsp           (rsp)
  );

endmodule
